FILE: rtl/rsp_pkg.sv
`timescale 1ns / 1ps

package rsp_pkg;

    typedef enum logic [2:0]
    {
        PH_HUNT,
        PH_BODY,
        PH_ESC,
        PH_HI,
        PH_LO
    } phase_t;

    typedef enum logic [2:0]
    {
        KIND_PAYLOAD = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_GOOD    = 3'd2,
        KIND_BAD     = 3'd3,
        KIND_GIVEUP  = 3'd4
    } kind_t;

    localparam logic [7:0] CHAR_START = 8'h24;   // '$'
    localparam logic [7:0] CHAR_END   = 8'h23;   // '#'
    localparam logic [7:0] CHAR_ESC   = 8'h7d;   // '}'
    localparam logic [7:0] CHAR_ACK   = 8'h2b;   // '+'
    localparam logic [7:0] CHAR_NAK   = 8'h2d;   // '-'
    localparam logic [7:0] ESC_XOR    = 8'h20;

    localparam logic [15:0] LEN_MAX  = 16'hffff;
    localparam logic [3:0]  FAIL_MAX = 4'hf;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY    = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;
    localparam logic [3:0]  RETRY_RESET    = 4'd10;

    typedef struct packed
    {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] count;
        logic        reply_valid;
        logic [7:0]  reply_char;
        logic        last;
    } result_t;

    typedef struct packed
    {
        logic [15:0] payload_capacity;
        logic [3:0]  retry_limit;
    } cfg_t;

    // Up to two results produced by one input beat.
    typedef struct packed
    {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    // Hex digit decode with no validity check; letters fold to lower case.
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c;
        if (c > 8'h39)
        begin
            if (c >= 8'h41 && c <= 8'h5a)
            begin
                folded = c + 8'h20;
            end
            return folded - 8'h61 + 8'h0a;
        end
        return c - 8'h30;
    endfunction

endpackage

FILE: rtl/rsp_stream_if.sv
`timescale 1ns / 1ps

interface rsp_stream_if #(parameter type payload_t = logic [7:0]);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/rsp_parser.sv
`timescale 1ns / 1ps

module rsp_parser
    import rsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output push_t      push
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] len_reg, len_next;
    logic [3:0]  fail_reg, fail_next;
    logic [3:0]  high_reg, high_next;

    logic [7:0]  digit;
    logic [7:0]  expect_sum;
    logic [15:0] len_inc;
    logic        below_cap;
    logic [3:0]  fail_inc;

    assign digit      = hex_value(rx_byte);
    assign expect_sum = {high_reg, 4'b0000} | digit;
    assign len_inc    = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;
    assign below_cap  = len_reg < cfg.payload_capacity;
    assign fail_inc   = (fail_reg < FAIL_MAX) ? fail_reg + 4'd1 : fail_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= '0;
            len_reg   <= '0;
            fail_reg  <= '0;
            high_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            fail_reg  <= fail_next;
            high_reg  <= high_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CHAR_START)
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (rx_byte == CHAR_ESC)
                    begin
                        phase_next = PH_ESC;
                    end
                    else if (rx_byte == CHAR_END)
                    begin
                        phase_next = PH_HI;
                    end
                end
                PH_ESC:  phase_next = (rx_byte == CHAR_END) ? PH_HI : PH_BODY;
                PH_HI:   phase_next = PH_LO;
                PH_LO:   phase_next = PH_HUNT;
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        sum_next  = sum_reg;
        len_next  = len_reg;
        fail_next = fail_reg;
        high_next = high_reg;
        push      = '0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == CHAR_ACK)
                    begin
                        fail_next        = '0;
                        push.num         = 2'd1;
                        push.first.kind  = KIND_ACK;
                        push.first.last  = 1'b1;
                    end
                    else if (rx_byte == CHAR_START)
                    begin
                        sum_next = '0;
                        len_next = '0;
                    end
                end
                PH_BODY:
                begin
                    if (rx_byte != CHAR_ESC && rx_byte != CHAR_END)
                    begin
                        sum_next         = sum_reg + rx_byte;
                        len_next         = len_inc;
                        push.num         = below_cap ? 2'd1 : 2'd0;
                        push.first.kind  = KIND_PAYLOAD;
                        push.first.data  = rx_byte;
                        push.first.count = len_reg;
                        push.first.last  = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    // Both the escape character and the raw byte enter the sum.
                    sum_next         = sum_reg + rx_byte + CHAR_ESC;
                    len_next         = len_inc;
                    push.num         = below_cap ? 2'd1 : 2'd0;
                    push.first.kind  = KIND_PAYLOAD;
                    push.first.data  = rx_byte ^ ESC_XOR;
                    push.first.count = len_reg;
                    push.first.last  = 1'b1;
                end
                PH_HI:
                begin
                    high_next = digit[3:0];
                end
                PH_LO:
                begin
                    push.first.count       = len_reg;
                    push.first.reply_valid = 1'b1;
                    push.first.last        = 1'b1;
                    if (expect_sum == sum_reg)
                    begin
                        fail_next             = '0;
                        push.num              = 2'd1;
                        push.first.kind       = KIND_GOOD;
                        push.first.reply_char = CHAR_ACK;
                    end
                    else
                    begin
                        push.first.kind       = KIND_BAD;
                        push.first.reply_char = CHAR_NAK;
                        if (fail_inc >= cfg.retry_limit)
                        begin
                            // Give up: reject, then accept the packet anyway.
                            fail_next               = '0;
                            push.num                = 2'd2;
                            push.first.last         = 1'b0;
                            push.second.kind        = KIND_GIVEUP;
                            push.second.count       = len_reg;
                            push.second.reply_valid = 1'b1;
                            push.second.reply_char  = CHAR_ACK;
                            push.second.last        = 1'b1;
                        end
                        else
                        begin
                            fail_next = fail_inc;
                            push.num  = 2'd1;
                        end
                    end
                end
                default:
                begin
                    push = '0;
                end
            endcase
        end
    end

endmodule

FILE: rtl/rsp_result_fifo.sv
`timescale 1ns / 1ps

module rsp_result_fifo
    import rsp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  push_t        push,
    output logic         room,
    rsp_stream_if.source res
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    result_t mem [DEPTH];

    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Two free entries are needed since one beat can produce two results.
    assign room        = fill_reg <= FILL_W'(DEPTH - 2);
    assign res.valid   = fill_reg != '0;
    assign res.payload = mem[rd_reg];
    assign pop         = res.valid && res.ready;

    always_comb
    begin
        case (push.num)
            2'd1:    wr_next = ptr_inc(wr_reg);
            2'd2:    wr_next = ptr_inc(ptr_inc(wr_reg));
            default: wr_next = wr_reg;
        endcase
        rd_next   = pop ? ptr_inc(rd_reg) : rd_reg;
        fill_next = fill_reg + FILL_W'(push.num) - FILL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem[ptr_inc(wr_reg)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: rtl/rsp_packet_receiver.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat                   Payload
// rx        in   valid & ready          rx_byte
// res       out  valid & ready          kind, data, count, reply_valid, reply_char, last
// cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// One received byte is taken per cycle while rx.ready is high; its results are
// written into the result queue on the accepting edge and reach res after earlier ones.
// The result queue drains one result per cycle while res.ready is high; a give-up
// byte yields two results. rx.ready falls while fewer than two queue entries are free.
// Reset is asynchronous and returns the parser to hunting with an empty queue.
module rsp_packet_receiver
    import rsp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    rsp_stream_if.sink             rx,
    rsp_stream_if.source           res
);

    cfg_t  cfg_reg;
    push_t push;
    logic  room;
    logic  accept;

    assign rx.ready = room;
    assign accept   = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_capacity <= CAPACITY_RESET;
            cfg_reg.retry_limit      <= RETRY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAPACITY: cfg_reg.payload_capacity <= cfg_wdata;
                REG_RETRY:    cfg_reg.retry_limit      <= cfg_wdata[3:0];
                default:      cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    rsp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.payload.rx_byte),
        .cfg     (cfg_reg),
        .push    (push)
    );

    rsp_result_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

endmodule
